[hw/rtl/tricorn_escape_time_defines.svh]
// assertion helpers for the rtl
`ifndef TRICORN_ESCAPE_TIME_DEFINES_SVH
`define TRICORN_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tet_pkg.sv]
package tet_pkg;

    // fixed point format and field widths
    localparam int Q_W       = 32;
    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;
    localparam int PIX_W     = 10;
    localparam int CFG_ADDR_W = 3;

    // truncated square keeps every bit above the fraction (never negative)
    localparam int SQ_W  = 2 * Q_W - 1 - FRAC_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam logic [SUM_W-1:0] ESC_BOUND = SUM_W'(4) << FRAC_BITS;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RE_ORIGIN  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_IM_ORIGIN  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_RE_STEP    = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_IM_STEP    = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_CROSS_GAIN = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIMIT = CFG_ADDR_W'(5);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0]     out_x;
        logic [PIX_W-1:0]     out_y;
        logic [ITER_BITS-1:0] iterations;
    } t_result;

    typedef struct packed {
        logic signed [Q_W-1:0] re_origin;
        logic signed [Q_W-1:0] im_origin;
        logic signed [Q_W-1:0] re_step;
        logic signed [Q_W-1:0] im_step;
        logic signed [Q_W-1:0] cross_gain;
        logic [ITER_BITS-1:0]  iteration_limit;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic map;
        logic sqr;
        logic step;
        logic done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cont;
    } t_status;

endpackage

[hw/rtl/tet_cfg_regs.sv]
module tet_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tet_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tet_pkg::Q_W-1:0]        i_cfg_data,
    output tet_pkg::t_cfg                  o_cfg
);
    import tet_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.re_origin       <= -(Q_W'(2) << FRAC_BITS);
            r_cfg.im_origin       <= -(Q_W'(2) << FRAC_BITS);
            r_cfg.re_step         <= Q_W'(1) << (FRAC_BITS - 8);
            r_cfg.im_step         <= Q_W'(1) << (FRAC_BITS - 8);
            r_cfg.cross_gain      <= -(Q_W'(2) << FRAC_BITS);
            r_cfg.iteration_limit <= ITER_BITS'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_RE_ORIGIN:  r_cfg.re_origin       <= i_cfg_data;
                REG_IM_ORIGIN:  r_cfg.im_origin       <= i_cfg_data;
                REG_RE_STEP:    r_cfg.re_step         <= i_cfg_data;
                REG_IM_STEP:    r_cfg.im_step         <= i_cfg_data;
                REG_CROSS_GAIN: r_cfg.cross_gain      <= i_cfg_data;
                REG_ITER_LIMIT: r_cfg.iteration_limit <= i_cfg_data[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

[hw/rtl/tet_ctrl.sv]
`include "tricorn_escape_time_defines.svh"

module tet_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  tet_pkg::t_status i_status,
    output tet_pkg::t_cmd    o_cmd
);
    import tet_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAP  = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;
    localparam logic [1:0] ST_STEP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_busy = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.cont) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_SQR;
                end else begin
                    o_cmd.done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    `TET_ASSERT_NEXT(a_start_maps, (i_start && r_state == ST_IDLE), (r_state == ST_MAP),
        "accepted transaction did not enter mapping")
    `TET_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(o_cmd), "more than one command at once")
    `TET_ASSERT_NOW(a_done_in_step, o_cmd.done, (r_state == ST_STEP && !i_status.cont),
        "finish issued outside the escape test")
    `TET_ASSERT_NEXT(a_done_idle, o_cmd.done, (!o_busy), "still busy after finish")

endmodule

[hw/rtl/tet_datapath.sv]
module tet_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tet_pkg::t_cmd    i_cmd,
    input  tet_pkg::t_pixel  i_pixel,
    input  tet_pkg::t_cfg    i_cfg,
    output tet_pkg::t_status o_status,
    output logic             o_valid,
    output tet_pkg::t_result o_result
);
    import tet_pkg::*;

    logic [PIX_W-1:0]      r_px;
    logic [PIX_W-1:0]      r_py;
    logic [Q_W-1:0]        r_cr;
    logic [Q_W-1:0]        r_ci;
    logic signed [Q_W-1:0] r_zr;
    logic signed [Q_W-1:0] r_zi;
    logic [ITER_BITS-1:0]  r_cnt;
    logic [SQ_W-1:0]       r_sq_r;
    logic [SQ_W-1:0]       r_sq_i;
    logic signed [Q_W-1:0] r_gz;
    t_result               r_res;
    logic                  r_valid;

    logic [PIX_W+Q_W-1:0]      map_re;
    logic [PIX_W+Q_W-1:0]      map_im;
    logic signed [2*Q_W-1:0]   prod_rr;
    logic signed [2*Q_W-1:0]   prod_ii;
    logic signed [2*Q_W-1:0]   prod_gr;
    logic signed [2*Q_W-1:0]   prod_cross;
    logic [SUM_W-1:0]          mag;

    // pixel to complex point
    assign map_re = (PIX_W+Q_W)'(r_px) * (PIX_W+Q_W)'($unsigned(i_cfg.re_step));
    assign map_im = (PIX_W+Q_W)'(r_py) * (PIX_W+Q_W)'($unsigned(i_cfg.im_step));

    // squares and gain product of the current z
    assign prod_rr = r_zr * r_zr;
    assign prod_ii = r_zi * r_zi;
    assign prod_gr = i_cfg.cross_gain * r_zr;

    // cross term of the update
    assign prod_cross = r_gz * r_zi;

    // escape test on registered squares
    assign mag           = SUM_W'(r_sq_r) + SUM_W'(r_sq_i);
    assign o_status.cont = (mag <= ESC_BOUND) && (r_cnt < i_cfg.iteration_limit);

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel.pixel_x;
            r_py <= i_pixel.pixel_y;
        end
        if (i_cmd.map) begin
            r_cr  <= $unsigned(i_cfg.re_origin) + map_re[Q_W-1:0];
            r_ci  <= $unsigned(i_cfg.im_origin) + map_im[Q_W-1:0];
            r_zr  <= '0;
            r_zi  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.sqr) begin
            r_sq_r <= prod_rr[2*Q_W-2:FRAC_BITS];
            r_sq_i <= prod_ii[2*Q_W-2:FRAC_BITS];
            r_gz   <= prod_gr[FRAC_BITS+Q_W-1:FRAC_BITS];
        end
        if (i_cmd.step) begin
            r_zr  <= r_sq_r[Q_W-1:0] - r_sq_i[Q_W-1:0] + r_cr;
            r_zi  <= prod_cross[FRAC_BITS+Q_W-1:FRAC_BITS] + r_ci;
            r_cnt <= r_cnt + ITER_BITS'(1);
        end
        if (i_cmd.done) begin
            r_res.out_x      <= r_px;
            r_res.out_y      <= r_py;
            r_res.iterations <= r_cnt;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.done;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

[hw/rtl/tricorn_escape_time.sv]
// channel   | direction | handshake                 | payload
// pixel     | in        | start high, busy low      | i_pixel (pixel_x, pixel_y)
// result    | out       | o_valid strobe, one cycle | o_result (out_x, out_y, iterations)
// config    | in        | i_cfg_valid, o_cfg_ready  | i_cfg_addr, i_cfg_data
//
// busy spans mapping and each square, test and update; the result strobes as busy drops
// each iteration forms squares and gain product, then cross product and update
// busy drops as the result is registered, so the next pixel may start while it is shown
// synchronous active-low reset restores the register defaults and idles the engine
// results cannot be stalled; config is always ready
module tricorn_escape_time (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  tet_pkg::t_pixel                i_pixel,
    output logic                           o_valid,
    output tet_pkg::t_result               o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tet_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tet_pkg::Q_W-1:0]        i_cfg_data
);
    import tet_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    // configuration registers
    tet_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer
    tet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic
    tet_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_pixel  (i_pixel),
        .i_cfg    (cfg),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
